// File: hdl/strmq_pkg.sv
`timescale 1ns / 1ps
// Shared codes, controller states, command/status bundles and helpers
// for the sparse-table range query block. No dependencies.
package strmq_pkg;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_RANGE = 2'd1;
   localparam logic [1:0] STAT_NOT_BUILT = 2'd2;

   localparam logic [1:0] CSR_FIND_MAX      = 2'd0;
   localparam logic [1:0] CSR_ELEMENT_COUNT = 2'd1;
   localparam logic [1:0] CSR_SIGNED_VALUES = 2'd2;

   localparam int unsigned POS_BITS   = 10;
   localparam int unsigned COUNT_BITS = 11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QCHK,
      ST_TA,
      ST_TB,
      ST_EA,
      ST_EB,
      ST_CMP
   } state_type;

   typedef struct packed {
      logic accept;
      logic wr_elem;
      logic resp_now;
      logic q_check;
      logic b_init;
      logic b_done;
      logic rd_ta;
      logic rd_tb;
      logic rd_ea;
      logic rd_eb;
      logic cmp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       out_free;
      logic       q_direct;
      logic       b_trivial;
      logic       b_last;
      logic       is_query;
   } stat_type;

   function automatic logic [3:0] flog2_10(input logic [POS_BITS-1:0] x);
      logic [3:0] r;
      r = 4'd0;
      for (int j = 0; j < POS_BITS; j++) begin
         if (x[j]) r = 4'(j);
      end
      return r;
   endfunction

endpackage

// File: hdl/strmq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module strmq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/strmq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences writes, table builds and queries.
// Depends on strmq_pkg.
module strmq_ctrl import strmq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      take;

   assign take       = (state_ff == ST_IDLE) && req_tvalid && stat.out_free;
   assign req_tready = (state_ff == ST_IDLE) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (stat.mode == MODE_QUERY) state_in = ST_QCHK;
               else if (stat.mode == MODE_BUILD && !stat.b_trivial) state_in = ST_TA;
            end
         end
         ST_QCHK: state_in = stat.q_direct ? ST_IDLE : ST_TA;
         ST_TA:   state_in = ST_TB;
         ST_TB:   state_in = ST_EA;
         ST_EA:   state_in = ST_EB;
         ST_EB:   state_in = ST_CMP;
         ST_CMP: begin
            if (stat.is_query || stat.b_last) state_in = ST_IDLE;
            else state_in = ST_TA;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = take;
            if (take) begin
               unique case (stat.mode)
                  MODE_WRITE: begin
                     cmd.wr_elem  = 1'b1;
                     cmd.resp_now = 1'b1;
                  end
                  MODE_BUILD: begin
                     cmd.b_done = stat.b_trivial;
                     cmd.b_init = !stat.b_trivial;
                  end
                  MODE_QUERY: ;
                  default: cmd.resp_now = 1'b1;
               endcase
            end
         end
         ST_QCHK: cmd.q_check = 1'b1;
         ST_TA:   cmd.rd_ta = 1'b1;
         ST_TB:   cmd.rd_tb = 1'b1;
         ST_EA:   cmd.rd_ea = 1'b1;
         ST_EB:   cmd.rd_eb = 1'b1;
         ST_CMP: begin
            cmd.cmp    = 1'b1;
            cmd.b_done = !stat.is_query && stat.b_last;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// File: hdl/strmq_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, element and window memories,
// build counters, query bounds, comparator and result register.
// Depends on strmq_pkg and strmq_ram.
module strmq_dp import strmq_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS = 1024,
   parameter int unsigned VALUE_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  in_mode,
   input  logic [9:0]  in_index,
   input  logic [31:0] in_value,
   input  logic [9:0]  in_left,
   input  logic [9:0]  in_right,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [9:0]  rsp_position,
   output logic [1:0]  rsp_status
);

   localparam int unsigned AW = $clog2(MAX_ELEMENTS);
   localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned KW = $clog2(AW + 1);
   localparam int unsigned NW = CW + COUNT_BITS;
   localparam int unsigned QW = CW + POS_BITS;

   logic                  find_max_ff, signed_ff, ready_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [1:0]            mode_ff;
   logic [POS_BITS-1:0]   lo_ff, hi_ff;
   logic [KW-1:0]         k_ff, s_ff;
   logic [AW-1:0]         i_ff, pa_ff, pb_ff, a_ff, b_ff;
   logic                  lvl0_ff;
   logic [VALUE_BITS-1:0] ka_ff;
   logic                  rsp_valid_ff;
   logic [POS_BITS-1:0]   rsp_pos_ff;
   logic [1:0]            rsp_stat_ff;

   logic [CW-1:0]         n;
   logic                  is_query, q_bad, q_direct, last_level, win_a;
   logic [KW-1:0]         lvl;
   logic [CW:0]           half, snd_sum;
   logic [AW-1:0]         snd, pos_a, pos_b, n_last, winner;
   logic [POS_BITS:0]     q_bpos;
   logic [AW+1:0]         next_span;
   logic [VALUE_BITS-1:0] kb, flip, key_a, key_b;
   logic                  idx_ok;
   logic [KW+AW-1:0]      tbl_rd_addr;
   logic [AW-1:0]         tbl_rd_data, elem_rd_addr;
   logic [VALUE_BITS-1:0] elem_rd_data;
   logic                  rsp_load;
   logic [POS_BITS-1:0]   rsp_pos_in;
   logic [1:0]            rsp_stat_in;

   assign n = ((NW'(count_ff) > NW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(count_ff));
   assign n_last   = AW'(n - CW'(1));
   assign is_query = (mode_ff == MODE_QUERY);

   assign q_bad    = (QW'(hi_ff) >= QW'(n));
   assign q_direct = !ready_ff || q_bad || (lo_ff == hi_ff);

   assign half    = (CW + 1)'(1) << (k_ff - KW'(1));
   assign snd_sum = (CW + 1)'(i_ff) + half;
   assign snd     = (snd_sum < (CW + 1)'(n)) ? AW'(snd_sum) : n_last;
   assign q_bpos  = ((POS_BITS + 1)'(hi_ff) + (POS_BITS + 1)'(1))
                    - ((POS_BITS + 1)'(1) << s_ff);

   assign lvl   = is_query ? s_ff : k_ff - KW'(1);
   assign pos_a = is_query ? AW'(lo_ff) : i_ff;
   assign pos_b = is_query ? AW'(q_bpos) : snd;

   assign next_span  = (AW + 2)'(1) << (k_ff + KW'(1));
   assign last_level = next_span > (AW + 2)'(n);

   assign flip  = signed_ff ? (VALUE_BITS'(1) << (VALUE_BITS - 1)) : '0;
   assign kb    = elem_rd_data;
   assign key_a = ka_ff ^ flip;
   assign key_b = kb ^ flip;
   assign win_a = find_max_ff ? (key_a >= key_b) : (key_a <= key_b);
   assign winner = win_a ? a_ff : b_ff;

   assign idx_ok = (QW'(in_index) < QW'(MAX_ELEMENTS));

   assign tbl_rd_addr  = cmd.rd_ta ? {lvl, pos_a} : {lvl, pb_ff};
   assign elem_rd_addr = cmd.rd_ea ? a_ff : b_ff;

   strmq_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_ELEMENTS)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_elem && idx_ok),
      .wr_addr (AW'(in_index)),
      .wr_data (VALUE_BITS'($signed(in_value))),
      .rd_en   (cmd.rd_ea || cmd.rd_eb),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rd_data)
   );

   strmq_ram #(
      .WIDTH (AW),
      .DEPTH (2 ** (KW + AW))
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (cmd.cmp && !is_query),
      .wr_addr ({k_ff, i_ff}),
      .wr_data (winner),
      .rd_en   (cmd.rd_ta || cmd.rd_tb),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   always_comb begin
      rsp_load    = 1'b0;
      rsp_pos_in  = '0;
      rsp_stat_in = STAT_OK;
      if (cmd.resp_now) begin
         rsp_load    = 1'b1;
         rsp_stat_in = (in_mode == MODE_WRITE) ? STAT_OK : STAT_BAD_RANGE;
      end else if (cmd.b_done) begin
         rsp_load = 1'b1;
      end else if (cmd.q_check && q_direct) begin
         rsp_load = 1'b1;
         if (!ready_ff) rsp_stat_in = STAT_NOT_BUILT;
         else if (q_bad) rsp_stat_in = STAT_BAD_RANGE;
         else rsp_pos_in = lo_ff;
      end else if (cmd.cmp && is_query) begin
         rsp_load   = 1'b1;
         rsp_pos_in = POS_BITS'(winner);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         find_max_ff  <= 1'b0;
         signed_ff    <= 1'b1;
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FIND_MAX:      find_max_ff <= csr_data[0];
               CSR_ELEMENT_COUNT: count_ff    <= csr_data;
               CSR_SIGNED_VALUES: signed_ff   <= csr_data[0];
               default: ;
            endcase
            if (csr_index == CSR_FIND_MAX || csr_index == CSR_ELEMENT_COUNT
                || csr_index == CSR_SIGNED_VALUES) ready_ff <= 1'b0;
         end
         if (cmd.wr_elem && idx_ok) ready_ff <= 1'b0;
         if (cmd.b_done) ready_ff <= 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= in_mode;
         lo_ff   <= (in_left < in_right) ? in_left : in_right;
         hi_ff   <= (in_left < in_right) ? in_right : in_left;
      end
      if (cmd.q_check) s_ff <= KW'(flog2_10(hi_ff - lo_ff));
      if (cmd.b_init) begin
         i_ff <= '0;
         k_ff <= KW'(1);
      end else if (cmd.cmp && !is_query) begin
         if (i_ff == n_last) begin
            i_ff <= '0;
            k_ff <= k_ff + KW'(1);
         end else begin
            i_ff <= i_ff + AW'(1);
         end
      end
      if (cmd.rd_ta) begin
         pa_ff   <= pos_a;
         pb_ff   <= pos_b;
         lvl0_ff <= (lvl == '0);
      end
      if (cmd.rd_tb) a_ff <= lvl0_ff ? pa_ff : tbl_rd_data;
      if (cmd.rd_ea) b_ff <= lvl0_ff ? pb_ff : tbl_rd_data;
      if (cmd.rd_eb) ka_ff <= elem_rd_data;
      if (rsp_load) begin
         rsp_pos_ff  <= rsp_pos_in;
         rsp_stat_ff <= rsp_stat_in;
      end
   end

   assign stat.mode      = in_mode;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;
   assign stat.q_direct  = q_direct;
   assign stat.b_trivial = (n < CW'(2));
   assign stat.b_last    = (i_ff == n_last) && last_level;
   assign stat.is_query  = is_query;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_status   = rsp_stat_ff;

endmodule

// File: hdl/sparse_table_range_min_query.sv
`timescale 1ns / 1ps
// Sparse-table range min/max query. Element write or unknown mode: response loaded on accept.
// Query: answered from the check state when settled by its bounds, otherwise after two
// window reads, two element reads and a compare, serialised by the single read port of
// the window memory and of the element memory. Build: the same reads and compare per entry.
// Reset clears control state, marks the table not built and loads the
// registers with find_max 0, element_count 0, signed_values 1.
module sparse_table_range_min_query import strmq_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS = 1024,
   parameter int unsigned VALUE_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // index[9:0], value[41:10], left[51:42], right[61:52]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // position[9:0]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   cmd_type    cmd;
   stat_type   stat;
   logic [9:0] rsp_position;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {6'd0, rsp_position};

   strmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   strmq_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_mode      (req_tuser),
      .in_index     (req_tdata[9:0]),
      .in_value     (req_tdata[41:10]),
      .in_left      (req_tdata[51:42]),
      .in_right     (req_tdata[61:52]),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_position (rsp_position),
      .rsp_status   (rsp_tuser)
   );

endmodule

// File: tb/sparse_table_range_min_query_checker.sv
`timescale 1ns / 1ps
// Transaction checker for sparse_table_range_min_query: tracks registers and
// elements, predicts every response and compares it. Depends on strmq_pkg.
module sparse_table_range_min_query_checker import strmq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data,
   output int          errors,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic [POS_BITS-1:0] position;
      logic [1:0]          status;
   } answer_type;

   logic [31:0]     elements [1024];
   logic            built;
   logic            find_max;
   logic [10:0]     count;
   logic            signed_cmp;
   answer_type      answers [$];

   // true when element a wins over or ties with element b
   function automatic bit keeps_left(input int a, input int b);
      logic [32:0] ka, kb;
      ka = {signed_cmp & elements[a][31], elements[a]};
      kb = {signed_cmp & elements[b][31], elements[b]};
      if (find_max) return $signed(ka) >= $signed(kb);
      return $signed(ka) <= $signed(kb);
   endfunction

   function automatic answer_type range_extreme(input logic [1:0] mode,
                                                input logic [63:0] d);
      answer_type ans;
      int lo, hi, n, best;
      ans = '{position: '0, status: STAT_OK};
      lo = d[51:42];
      hi = d[61:52];
      n = (count > 1024) ? 1024 : count;
      if (mode == MODE_WRITE || mode == MODE_BUILD) return ans;
      if (mode != MODE_QUERY) begin
         ans.status = STAT_BAD_RANGE;
         return ans;
      end
      if (lo > hi) begin
         best = lo;
         lo = hi;
         hi = best;
      end
      if (!built) ans.status = STAT_NOT_BUILT;
      else if (hi >= n) ans.status = STAT_BAD_RANGE;
      else begin
         best = lo;
         for (int i = lo + 1; i <= hi; i++) begin
            if (!keeps_left(best, i)) best = i;
         end
         ans.position = best[POS_BITS-1:0];
      end
      return ans;
   endfunction

   assign pending = answers.size();

   always @(posedge clock) begin
      answer_type exp_ans;
      if (reset) begin
         built <= 1'b0;
         find_max <= 1'b0;
         count <= '0;
         signed_cmp <= 1'b1;
         errors <= 0;
         checked <= 0;
         answers.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIND_MAX:      find_max <= csr_data[0];
               CSR_ELEMENT_COUNT: count <= csr_data;
               CSR_SIGNED_VALUES: signed_cmp <= csr_data[0];
               default: ;
            endcase
            if (csr_index == CSR_FIND_MAX || csr_index == CSR_ELEMENT_COUNT
                || csr_index == CSR_SIGNED_VALUES) built <= 1'b0;
         end
         if (req_tvalid && req_tready) begin
            answers.insert(answers.size(), range_extreme(req_tuser, req_tdata));
            if (req_tuser == MODE_WRITE) begin
               elements[req_tdata[9:0]] = req_tdata[41:10];
               built <= 1'b0;
            end else if (req_tuser == MODE_BUILD) begin
               built <= 1'b1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            checked <= checked + 1;
            if (answers.size() == 0) begin
               $display("%0t: unexpected response position %0d status %0d",
                        $time, rsp_tdata[9:0], rsp_tuser);
               errors <= errors + 1;
            end else begin
               exp_ans = answers.pop_front();
               if (rsp_tdata[9:0] != exp_ans.position || rsp_tuser != exp_ans.status) begin
                  $display("%0t: expected position %0d status %0d, got position %0d status %0d",
                           $time, exp_ans.position, exp_ans.status, rsp_tdata[9:0], rsp_tuser);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

// File: tb/sparse_table_range_min_query_test.sv
`timescale 1ns / 1ps
// Top of the sparse_table_range_min_query testbench: clock, reset, stimulus
// and verdict. Depends on strmq_pkg, the block and the checker module.
module sparse_table_range_min_query_test;
   import strmq_pkg::*;

   localparam logic [1:0] MODE_UNDEFINED = 2'd3;
   localparam int         STALL_LIMIT    = 200000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [10:0] csr_data;
   int          errors, pending, checked;
   int          idle_cycles;
   bit          steady;
   bit          hold_rsp;
   int          phases;

   sparse_table_range_min_query dut (.*);
   sparse_table_range_min_query_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] element_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         4, 5, 6: return 32'($urandom_range(0, 4)) - 32'd2;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input logic [1:0] mode, input int idx, input logic [31:0] val,
                       input int lo, input int hi);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {2'b0, 10'(hi), 10'(lo), val, 10'(idx)};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 11'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic query(input int lo, input int hi);
      send(MODE_QUERY, $urandom_range(0, 1023), $urandom, lo, hi);
   endtask

   task automatic build();
      send(MODE_BUILD, $urandom_range(0, 1023), $urandom, $urandom_range(0, 1023),
           $urandom_range(0, 1023));
   endtask

   task automatic store(input int idx, input logic [31:0] val);
      send(MODE_WRITE, idx, val, $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   task automatic run_phase(input int n, input int items, input bit rebuilds);
      int r;
      write_reg(CSR_FIND_MAX, $urandom_range(0, 1));
      write_reg(CSR_ELEMENT_COUNT, n);
      write_reg(CSR_SIGNED_VALUES, $urandom_range(0, 1));
      for (int i = 0; i < n; i++) store(i, element_value());
      build();
      for (int j = 0; j < items; j++) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            if (n > 0 && $urandom_range(0, 9) != 0)
               query($urandom_range(0, n - 1), $urandom_range(0, n - 1));
            else
               query($urandom_range(0, 1023), $urandom_range(0, 1023));
         end else if (r < 80) begin
            store($urandom_range(0, 1023), element_value());
         end else if (r < 92) begin
            if (rebuilds) build();
         end else if (r < 97) begin
            send(MODE_UNDEFINED, $urandom_range(0, 1023), $urandom,
                 $urandom_range(0, 1023), $urandom_range(0, 1023));
         end else begin
            drain();
         end
      end
      phases++;
   endtask

   // response side: random back-pressure plus one long hold-off
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = gap_len();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         for (int c = $urandom_range(1, 20); c > 0 && !hold_rsp; c--) @(posedge clock);
      end
   end

   // stall watchdog
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", idle_cycles);
            $display("sparse_table_range_min_query: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int n;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_WRITE;
      csr_valid = 1'b0;
      csr_index = CSR_FIND_MAX;
      csr_data = '0;
      steady = 1'b0;
      hold_rsp = 1'b0;
      phases = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty array, not built, value extremes, ties, bound cases
      query(0, 0);
      build();
      query(0, 0);
      write_reg(CSR_ELEMENT_COUNT, 4);
      store(0, 32'h8000_0000);
      store(1, 32'h7fff_ffff);
      store(2, 32'h0);
      store(3, 32'h8000_0000);
      store(1023, 32'hffff_ffff);
      query(1, 2);
      build();
      query(1, 3);
      query(3, 1);
      query(2, 2);
      query(0, 4);
      query(1023, 1023);
      send(MODE_UNDEFINED, 1023, 32'hffff_ffff, 1023, 1023);
      write_reg(CSR_FIND_MAX, 1);
      build();
      query(0, 3);
      write_reg(CSR_SIGNED_VALUES, 0);
      build();
      query(0, 3);
      query(3, 0);

      // hold off the response side while queries keep coming
      drain();
      hold_rsp = 1'b1;
      for (int j = 0; j < 12; j++) query($urandom_range(0, 3), $urandom_range(0, 3));

      for (int p = 0; p < 12; p++) begin
         steady = (p % 4 == 3);
         case (p)
            0: n = 0;
            1: n = 1;
            2: n = 2;
            6: n = 300;
            default: n = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 8)
                                                     : $urandom_range(9, 40);
         endcase
         run_phase(n, 40, n <= 64);
      end
      steady = 1'b0;

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d register settings and %0d checked responses",
               phases + 4, checked);
      $display("writes, builds, queries and undefined modes under random back-pressure");
      if (errors == 0 && pending == 0)
         $display("sparse_table_range_min_query: match");
      else
         $display("sparse_table_range_min_query: mismatch");
      $finish;
   end

endmodule

// File: sim.f
hdl/strmq_pkg.sv
hdl/strmq_ram.sv
hdl/strmq_ctrl.sv
hdl/strmq_dp.sv
hdl/sparse_table_range_min_query.sv
tb/sparse_table_range_min_query_checker.sv
tb/sparse_table_range_min_query_test.sv
